[rtl/core/ceb_pkg.sv]
// shared types and constants for the coincidence event builder
// request payload structs, hit store entry, register indexes and reset values
// no dependencies
package ceb_pkg;

  localparam int TS_W       = 48;
  localparam int CAL_W      = 37;
  localparam int ENERGY_W   = 16;
  localparam int CH_W       = 2;
  localparam int SIZE_W     = 5;
  localparam int WINDOW_W   = 32;
  localparam int CALIB_W    = 48;
  localparam int COEF_W     = 24;
  localparam int NUM_CALIB  = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB3 = 3'd4;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000;
  localparam logic [CALIB_W-1:0]  CALIB_RESET  = 48'd65536;

  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // saturation bound for the calibrated sum
  localparam logic signed [41:0] CAL_LIMIT = 42'sd42955571200;

  typedef struct packed {
    logic                kind;
    logic [CH_W-1:0]     det_channel;
    logic [ENERGY_W-1:0] adc_energy;
    logic [TS_W-1:0]     timestamp;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     out_channel;
    logic [ENERGY_W-1:0] out_energy;
    logic [CAL_W-1:0]    calibrated_energy;
    logic [TS_W-1:0]     out_time;
    logic [SIZE_W-1:0]   event_size;
    logic                overflowed;
    logic                last_hit;
  } out_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [ENERGY_W-1:0] energy;
    logic [CAL_W-1:0]    calibrated;
    logic [TS_W-1:0]     time_stamp;
  } hit_entry_t;

endpackage

[rtl/core/ceb_calib.sv]
// two-stage energy calibration: energy * gain, then + offset with saturation
// uses ceb_pkg for widths and the saturation bound
// the product and offset are registered, then the saturated sum is registered as the result
module ceb_calib (
  input  logic                             clk,
  input  logic [ceb_pkg::ENERGY_W-1:0]     energy,
  input  logic [ceb_pkg::CALIB_W-1:0]      calib,
  output logic signed [ceb_pkg::CAL_W-1:0] cal
);

  logic signed [40:0] energy_x;
  logic signed [40:0] gain_x;
  logic signed [40:0] prod_nxt;
  logic signed [40:0] prod_r;
  logic signed [23:0] offset_nxt;
  logic signed [23:0] offset_r;
  logic signed [41:0] sum;
  logic signed [41:0] sat;
  logic signed [ceb_pkg::CAL_W-1:0] cal_r;

  assign energy_x   = 41'($signed({1'b0, energy}));
  assign gain_x     = 41'($signed(calib[ceb_pkg::COEF_W-1:0]));
  assign prod_nxt   = energy_x * gain_x;
  assign offset_nxt = $signed(calib[ceb_pkg::CALIB_W-1:ceb_pkg::COEF_W]);

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    offset_r <= offset_nxt;
  end

  assign sum = 42'(prod_r) + 42'(offset_r);

  always_comb begin
    priority if (sum > ceb_pkg::CAL_LIMIT) begin
      sat = ceb_pkg::CAL_LIMIT;
    end else if (sum < -ceb_pkg::CAL_LIMIT) begin
      sat = -ceb_pkg::CAL_LIMIT;
    end else begin
      sat = sum;
    end
  end

  always_ff @(posedge clk) begin
    cal_r <= sat[ceb_pkg::CAL_W-1:0];
  end

  assign cal = cal_r;

endmodule

[rtl/core/ceb_store.sv]
// hit store: one write port, one read port with registered read data
// entries typed by ceb_pkg::hit_entry_t, no reset
module ceb_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ceb_pkg::hit_entry_t wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output ceb_pkg::hit_entry_t rd_data
);

  ceb_pkg::hit_entry_t mem [DEPTH];
  ceb_pkg::hit_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/coincidence_event_builder.sv]
// coincidence event builder: a hit goes from acceptance to storage through accept,
// multiply, offset and saturate, and store write; in_stall is high meanwhile
// closing an event drains its stored hits one result at a time (store read,
// output load), held while out_stall holds the output register
// a closing hit is stored after the drain; a flush returns to idle after it
// reset clears control and configuration registers; the hit store is not cleared
module coincidence_event_builder #(
  parameter int MAX_HITS     = 16,
  parameter int NUM_CHANNELS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ceb_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ceb_pkg::out_item_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [ceb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ceb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int CW = $clog2(MAX_HITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_STORE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       event_open_r, event_open_nxt;
  logic [ceb_pkg::TS_W-1:0] first_time_r, first_time_nxt;
  logic [CW-1:0] hit_count_r, hit_count_nxt;
  logic       drop_flag_r, drop_flag_nxt;
  logic       join_r, join_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  ceb_pkg::out_item_t out_data_r, out_data_nxt;
  ceb_pkg::in_item_t  hit_r;

  logic [ceb_pkg::WINDOW_W-1:0] window_r;
  logic [ceb_pkg::CALIB_W-1:0]  calib_r [ceb_pkg::NUM_CALIB];

  logic                    accept;
  logic [ceb_pkg::TS_W:0]  bound;
  logic signed [ceb_pkg::CAL_W-1:0] cal;
  logic                    ch_ok;
  logic                    out_free;
  logic                    is_last;

  logic                st_wr_en;
  logic [AW-1:0]       st_wr_addr;
  ceb_pkg::hit_entry_t st_wr_data;
  logic                st_rd_en;
  ceb_pkg::hit_entry_t st_rd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= ceb_pkg::WINDOW_RESET;
      for (int i = 0; i < ceb_pkg::NUM_CALIB; i++) begin
        calib_r[i] <= ceb_pkg::CALIB_RESET;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ceb_pkg::REG_WINDOW: window_r   <= cfg_data[ceb_pkg::WINDOW_W-1:0];
        ceb_pkg::REG_CALIB0: calib_r[0] <= cfg_data;
        ceb_pkg::REG_CALIB1: calib_r[1] <= cfg_data;
        ceb_pkg::REG_CALIB2: calib_r[2] <= cfg_data;
        ceb_pkg::REG_CALIB3: calib_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  // window bound without wrap
  assign bound = {1'b0, first_time_r} + (ceb_pkg::TS_W + 1)'(window_r);

  ceb_calib u_calib (
    .clk    (clk),
    .energy (hit_r.adc_energy),
    .calib  (calib_r[hit_r.det_channel]),
    .cal    (cal)
  );

  assign ch_ok = ({1'b0, hit_r.det_channel} < 3'(NUM_CHANNELS));

  ceb_store #(
    .DEPTH (MAX_HITS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (st_rd_data)
  );

  assign st_wr_addr            = hit_count_r[AW-1:0];
  assign st_wr_data.channel    = hit_r.det_channel;
  assign st_wr_data.energy     = hit_r.adc_energy;
  assign st_wr_data.calibrated = ch_ok ? cal : '0;
  assign st_wr_data.time_stamp = hit_r.timestamp;

  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = (({1'b0, rd_idx_r} + (CW + 1)'(1)) == {1'b0, hit_count_r});

  always_comb begin
    state_nxt      = state_r;
    event_open_nxt = event_open_r;
    first_time_nxt = first_time_r;
    hit_count_nxt  = hit_count_r;
    drop_flag_nxt  = drop_flag_r;
    join_nxt       = join_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    st_wr_en       = 1'b0;
    st_rd_en       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          join_nxt  = event_open_r && ({1'b0, in_data.timestamp} < bound);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_SUM;
      end
      S_SUM: begin
        rd_idx_nxt = '0;
        priority if (hit_r.kind == ceb_pkg::KIND_FLUSH) begin
          if (event_open_r) begin
            state_nxt = S_RD;
          end else begin
            hit_count_nxt = '0;
            drop_flag_nxt = 1'b0;
            state_nxt     = S_IDLE;
          end
        end else if (join_r) begin
          state_nxt = S_STORE;
        end else if (event_open_r) begin
          state_nxt = S_RD;
        end else begin
          event_open_nxt = 1'b1;
          first_time_nxt = hit_r.timestamp;
          hit_count_nxt  = '0;
          drop_flag_nxt  = 1'b0;
          state_nxt      = S_STORE;
        end
      end
      S_RD: begin
        st_rd_en  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.out_channel       = st_rd_data.channel;
          out_data_nxt.out_energy        = st_rd_data.energy;
          out_data_nxt.calibrated_energy = st_rd_data.calibrated;
          out_data_nxt.out_time          = st_rd_data.time_stamp;
          out_data_nxt.event_size        = ceb_pkg::SIZE_W'(hit_count_r);
          out_data_nxt.overflowed        = drop_flag_r;
          out_data_nxt.last_hit          = is_last;
          rd_idx_nxt                     = rd_idx_r + CW'(1);
          if (is_last) begin
            hit_count_nxt = '0;
            drop_flag_nxt = 1'b0;
            if (hit_r.kind == ceb_pkg::KIND_FLUSH) begin
              event_open_nxt = 1'b0;
              state_nxt      = S_IDLE;
            end else begin
              // closing hit opens the next event
              event_open_nxt = 1'b1;
              first_time_nxt = hit_r.timestamp;
              state_nxt      = S_STORE;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_STORE: begin
        if (hit_count_r < CW'(MAX_HITS)) begin
          st_wr_en      = 1'b1;
          hit_count_nxt = hit_count_r + CW'(1);
        end else begin
          drop_flag_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      event_open_r <= 1'b0;
      first_time_r <= '0;
      hit_count_r  <= '0;
      drop_flag_r  <= 1'b0;
      join_r       <= 1'b0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      event_open_r <= event_open_nxt;
      first_time_r <= first_time_nxt;
      hit_count_r  <= hit_count_nxt;
      drop_flag_r  <= drop_flag_nxt;
      join_r       <= join_nxt;
      rd_idx_r     <= rd_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
